>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// invariant
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

>>> sv/wbpm_pkg.sv
package wbpm_pkg;

    localparam int CHANNELS       = 8;
    localparam int MAX_BLOCKS     = 64;
    localparam int SAMPLE_BITS    = 24;
    localparam int CH_BITS        = $clog2(CHANNELS);
    localparam int PTR_BITS       = $clog2(MAX_BLOCKS);
    localparam int WIN_BITS       = 7;
    localparam int ACT_BITS       = 4;
    localparam int RING_DEPTH     = CHANNELS * MAX_BLOCKS;
    localparam int RING_ADDR_BITS = CH_BITS + PTR_BITS;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_BLOCKS   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_CHANNELS = 1'b1;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 7'd64;
    localparam logic [ACT_BITS-1:0] ACTIVE_RESET = 4'd2;

    typedef logic [SAMPLE_BITS-1:0] mag_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic scan_read;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic metered;
        logic is_end;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

>>> sv/wbpm_in_if.sv
interface wbpm_in_if;
    import wbpm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   block_end;

    modport source (output valid, output channel, output sample, output block_end,
                    input ready);
    modport sink (input valid, input channel, input sample, input block_end,
                  output ready);
endinterface

>>> sv/wbpm_out_if.sv
interface wbpm_out_if;
    import wbpm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_BITS-1:0]     out_channel;
    logic [SAMPLE_BITS-1:0] window_peak;

    modport source (output valid, output out_channel, output window_peak, input ready);
    modport sink (input valid, input out_channel, input window_peak, output ready);
endinterface

>>> sv/windowed_block_peak_meter.sv
// a metered block-end request steps through the update, scan, wait and done states before the
// result register loads; other requests return to idle after the update state; the ring scan
// reads one entry per cycle from one memory port; a new request is taken only in the idle state
// the result register lets the next request in while a result waits
// reset: window_blocks 64, active_channels 2, peaks and pointers zero
// unwritten ring entries read as zero through per-channel fill counts, no clearing pass
`include "assert_macros.svh"

module windowed_block_peak_meter (
    input  logic                               clk,
    input  logic                               rst_n,
    wbpm_in_if.sink                            samples,
    wbpm_out_if.source                         results,
    input  logic                               cfg_we,
    input  logic [wbpm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wbpm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import wbpm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    wbpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wbpm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_channel   (samples.channel),
        .in_sample    (samples.sample),
        .in_block_end (samples.block_end),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .out_channel  (results.out_channel),
        .out_peak     (results.window_peak),
        .cmd          (cmd),
        .stat         (stat)
    );

    `ASSERT_NEXT(a_busy_after_request, samples.valid && samples.ready, !samples.ready, "ready after accept")
    `ASSERT_IMPL(a_peak_range, results.valid, results.window_peak <= 24'h800000, "peak out of range")
    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "commands overlap")
    `ASSERT_IMPL(a_load_free, cmd.load_out, !results.valid || results.ready, "result overwritten")

endmodule

>>> sv/wbpm_ctrl.sv
module wbpm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wbpm_pkg::stat_t stat,
    output wbpm_pkg::cmd_t  cmd
);
    import wbpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (stat.metered && stat.is_end)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/wbpm_datapath.sv
module wbpm_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [wbpm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [wbpm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [wbpm_pkg::CH_BITS-1:0]          in_channel,
    input  logic [wbpm_pkg::SAMPLE_BITS-1:0]      in_sample,
    input  logic                                  in_block_end,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [wbpm_pkg::CH_BITS-1:0]          out_channel,
    output logic [wbpm_pkg::SAMPLE_BITS-1:0]      out_peak,
    input  wbpm_pkg::cmd_t                        cmd,
    output wbpm_pkg::stat_t                       stat
);
    import wbpm_pkg::*;

    // configuration
    logic [WIN_BITS-1:0] window_blocks_reg;
    logic [ACT_BITS-1:0] active_channels_reg;
    logic [WIN_BITS-1:0] win_eff;
    logic [ACT_BITS-1:0] act_eff;

    // captured request
    logic [CH_BITS-1:0] ch_reg;
    mag_t               mag_reg;
    logic               end_reg;
    mag_t               mag_next;

    // per-channel state
    mag_t                block_peak_reg [CHANNELS];
    logic [PTR_BITS-1:0] wr_ptr_reg     [CHANNELS];
    logic [WIN_BITS-1:0] fill_reg       [CHANNELS];

    // ring memory
    mag_t                      ring_mem [RING_DEPTH];
    mag_t                      mem_q_reg;
    logic [RING_ADDR_BITS-1:0] waddr;
    logic [RING_ADDR_BITS-1:0] raddr;
    logic                      ring_we;

    // scan
    logic [WIN_BITS-1:0] scan_idx_reg;
    logic                rd_pend_reg;
    logic                rd_ok_reg;
    mag_t                best_reg;

    // output register
    logic               out_valid_reg;
    logic [CH_BITS-1:0] out_ch_reg;
    mag_t               out_peak_reg;

    mag_t                bp_cur;
    mag_t                new_peak;
    logic [PTR_BITS-1:0] wp_raw;
    logic [PTR_BITS-1:0] wp_eff;
    logic [WIN_BITS-1:0] wp_inc;
    logic [PTR_BITS-1:0] wp_new;
    logic [WIN_BITS-1:0] fill_cur;
    logic [WIN_BITS-1:0] fill_new;
    logic                metered;

    always_comb
    begin
        if (window_blocks_reg == '0)
        begin
            win_eff = WIN_BITS'(1);
        end
        else if (window_blocks_reg > WIN_BITS'(MAX_BLOCKS))
        begin
            win_eff = WIN_BITS'(MAX_BLOCKS);
        end
        else
        begin
            win_eff = window_blocks_reg;
        end

        if (active_channels_reg > ACT_BITS'(CHANNELS))
        begin
            act_eff = ACT_BITS'(CHANNELS);
        end
        else
        begin
            act_eff = active_channels_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_blocks_reg   <= WINDOW_RESET;
            active_channels_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_BLOCKS:
                begin
                    window_blocks_reg <= cfg_data[WIN_BITS-1:0];
                end
                REG_ACTIVE_CHANNELS:
                begin
                    active_channels_reg <= cfg_data[ACT_BITS-1:0];
                end
                default:
                begin
                    window_blocks_reg <= window_blocks_reg;
                end
            endcase
        end
    end

    // two's complement magnitude, most negative value gives 2^(n-1)
    assign mag_next = in_sample[SAMPLE_BITS-1] ? (~in_sample + mag_t'(1)) : in_sample;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg  <= in_channel;
            mag_reg <= mag_next;
            end_reg <= in_block_end;
        end
    end

    always_comb
    begin
        bp_cur   = block_peak_reg[ch_reg];
        new_peak = (mag_reg > bp_cur) ? mag_reg : bp_cur;
        wp_raw   = wr_ptr_reg[ch_reg];
        wp_eff   = ({1'b0, wp_raw} >= win_eff) ? '0 : wp_raw;
        wp_inc   = {1'b0, wp_eff} + WIN_BITS'(1);
        wp_new   = (wp_inc >= win_eff) ? '0 : wp_inc[PTR_BITS-1:0];
        fill_cur = fill_reg[ch_reg];
        fill_new = (wp_inc > fill_cur) ? wp_inc : fill_cur;
        metered  = {1'b0, ch_reg} < act_eff;
        ring_we  = cmd.update && metered && end_reg;
        waddr    = {ch_reg, wp_eff};
        raddr    = {ch_reg, scan_idx_reg[PTR_BITS-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                block_peak_reg[c] <= '0;
                wr_ptr_reg[c]     <= '0;
                fill_reg[c]       <= '0;
            end
        end
        else if (cmd.update && metered)
        begin
            if (end_reg)
            begin
                block_peak_reg[ch_reg] <= '0;
                wr_ptr_reg[ch_reg]     <= wp_new;
                fill_reg[ch_reg]       <= fill_new;
            end
            else
            begin
                block_peak_reg[ch_reg] <= new_peak;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[waddr] <= new_peak;
        end
        if (cmd.scan_read)
        begin
            mem_q_reg <= ring_mem[raddr];
        end
    end

    // entries past the fill count were never written and read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            best_reg     <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_read;
            rd_ok_reg   <= scan_idx_reg < fill_reg[ch_reg];
            if (cmd.update)
            begin
                scan_idx_reg <= '0;
                best_reg     <= '0;
            end
            else
            begin
                if (cmd.scan_read)
                begin
                    scan_idx_reg <= scan_idx_reg + WIN_BITS'(1);
                end
                if (rd_pend_reg && rd_ok_reg && (mem_q_reg > best_reg))
                begin
                    best_reg <= mem_q_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_ch_reg   <= ch_reg;
            out_peak_reg <= best_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign out_peak    = out_peak_reg;

    assign stat.metered   = metered;
    assign stat.is_end    = end_reg;
    assign stat.scan_last = scan_idx_reg == (win_eff - WIN_BITS'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule
